FILE: rtl/lud_pkg.sv
// ----------------------------------------------------------------------------
// lud_pkg: shared types and constants for the LU factorization block
// Holds the controller state type and the command/status structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lud_pkg;

    localparam int FRAC = 16;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ACC_RD,
        ST_ACC_WAIT,
        ST_MUL_RD,
        ST_MUL_WAIT,
        ST_MUL,
        ST_SUB,
        ST_DIV,
        ST_WRITE,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } lud_state_t;

    // Datapath operations requested by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD_ACC,
        OP_LOAD_A,
        OP_LOAD_B,
        OP_MUL,
        OP_SUB,
        OP_DIV_START,
        OP_LOAD_PIV
    } lud_op_t;

    typedef struct packed {
        lud_op_t op;
        logic    wr_acc;    // write accumulator (or quotient) to memory
        logic    wr_in;     // write input element to memory
        logic    div_zero;  // write zero instead of quotient
        logic    use_quot;  // write quotient
    } lud_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic piv_zero;
        logic rd_zero;      // memory read data is zero
    } lud_stat_t;

endpackage

FILE: rtl/lu_decomposition_doolittle.sv
// ----------------------------------------------------------------------------
// lu_decomposition_doolittle: Doolittle LU factorization, Q16.16
// Loads an n x n matrix, factors it in place and streams out packed L/U.
//
//   channel   direction  payload
//   s_*       in         tdata: element_value[31:0]
//   m_*       out        tdata: factor_value, row_index, column_index;
//                        tuser: singular; tlast: last_of_run
//   cfg_*     in         matrix_size
//
// Load accepts one element per cycle. Each factor element reads its accumulator,
// then takes one A load, B load, multiply and subtract per multiply-accumulate on
// the shared multiplier; an L element adds a bit-serial division, and each row
// loads its pivot. Readout reads the next element once the last is accepted.
// Reset is synchronous, active low; the store needs no clearing.
// Stalls on m_tready hold the current result.
// ----------------------------------------------------------------------------
module lu_decomposition_doolittle #(
    parameter int MAX_SIZE    = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // element_value[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // factor_value[31:0], row_index, column_index, pad
    output logic        m_tuser,    // singular
    output logic        m_tlast
);
    import lud_pkg::*;

    lud_cmd_t  cmd;
    lud_stat_t stat;
    logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] waddr, raddr;
    logic signed [31:0] rd_value;
    logic [2:0] row, col;

    assign cfg_ready = 1'b1;

    lud_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_size  (cfg_data),
        .cfg_we    (cfg_valid),
        .in_fire   (s_tvalid & s_tready),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (row),
        .out_col   (col),
        .out_last  (m_tlast),
        .out_sing  (m_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .waddr     (waddr),
        .raddr     (raddr)
    );

    lud_datapath #(.MAX_SIZE(MAX_SIZE), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .waddr    (waddr),
        .raddr    (raddr),
        .in_value (s_tdata),
        .stat     (stat),
        .rd_value (rd_value)
    );

    assign m_tdata = {2'b00, col, row, rd_value};
endmodule

FILE: rtl/lud_ram.sv
// ----------------------------------------------------------------------------
// lud_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lud_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/lud_datapath.sv
// ----------------------------------------------------------------------------
// lud_datapath: storage and arithmetic for the LU factorization
// Holds the matrix memory, the accumulator, a multiplier with a registered
// product and a restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lud_datapath #(
    parameter int MAX_SIZE    = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lud_pkg::lud_cmd_t    cmd,
    input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] waddr,
    input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] raddr,
    input  logic signed [31:0]   in_value,
    output lud_pkg::lud_stat_t   stat,
    output logic signed [31:0]   rd_value
);
    import lud_pkg::*;

    localparam int EW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int PW    = 2 * EW;
    localparam int NW    = EW + FRAC + 1;   // dividend magnitude width
    localparam int QW    = NW;
    localparam int CW    = $clog2(QW + 1);
    localparam logic signed [EW-1:0] VMAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic signed [EW-1:0] VMIN = {1'b1, {(EW-1){1'b0}}};

    logic               we;
    logic signed [EW-1:0] wdata, rdata;
    logic signed [EW-1:0] acc_reg, a_reg, b_reg, piv_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [EW-1:0] mq_reg;
    logic signed [EW-1:0] in_sat;

    // Divider state.
    logic [NW-1:0] rem_reg, dvd_reg;
    logic [EW-1:0] dvs_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg, busy_reg;
    logic signed [EW-1:0] quo_sat;

    // Saturate the 32-bit input to the value width.
    always_comb begin
        if (EW == 32) begin
            in_sat = in_value[EW-1:0];
        end else if ($signed(in_value) > $signed({{(32-EW){VMAX[EW-1]}}, VMAX})) begin
            in_sat = VMAX;
        end else if ($signed(in_value) < $signed({{(32-EW){VMIN[EW-1]}}, VMIN})) begin
            in_sat = VMIN;
        end else begin
            in_sat = in_value[EW-1:0];
        end
    end

    // Rounded and saturated product, taken from the registered product.
    logic signed [PW:0] prnd;
    logic signed [PW-FRAC:0] pshift;
    always_comb begin
        prnd   = {prod_reg[PW-1], prod_reg} + (PW+1)'(1 << (FRAC-1));
        pshift = prnd[PW:FRAC];
        if (pshift > $signed({{(PW-FRAC+1-EW){1'b0}}, VMAX})) begin
            mq_reg = VMAX;
        end else if (pshift < $signed({{(PW-FRAC+1-EW){1'b1}}, VMIN})) begin
            mq_reg = VMIN;
        end else begin
            mq_reg = pshift[EW-1:0];
        end
    end

    // Saturating subtraction.
    logic signed [EW:0] diff;
    assign diff = {acc_reg[EW-1], acc_reg} - {mq_reg[EW-1], mq_reg};

    // Quotient sign and saturation.
    logic signed [QW:0] qs;
    always_comb begin
        qs = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        if (qs > $signed({{(QW+1-EW){1'b0}}, VMAX})) begin
            quo_sat = VMAX;
        end else if (qs < $signed({{(QW+1-EW){1'b1}}, VMIN})) begin
            quo_sat = VMIN;
        end else begin
            quo_sat = qs[EW-1:0];
        end
    end

    // Memory write selection.
    always_comb begin
        we    = cmd.wr_in | cmd.wr_acc;
        if (cmd.wr_in) begin
            wdata = in_sat;
        end else if (cmd.div_zero) begin
            wdata = '0;
        end else if (cmd.use_quot) begin
            wdata = quo_sat;
        end else begin
            wdata = acc_reg;
        end
    end

    lud_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_mem (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Operand, accumulator and product registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD_ACC: acc_reg <= rdata;
            OP_LOAD_A:   a_reg   <= rdata;
            OP_LOAD_B:   b_reg   <= rdata;
            OP_LOAD_PIV: piv_reg <= rdata;
            OP_MUL:      prod_reg <= a_reg * b_reg;
            OP_SUB: begin
                if (diff > $signed({1'b0, VMAX})) begin
                    acc_reg <= VMAX;
                end else if (diff < $signed({1'b1, VMIN})) begin
                    acc_reg <= VMIN;
                end else begin
                    acc_reg <= diff[EW-1:0];
                end
            end
            default: ;
        endcase
    end

    // Restoring divider: |acc| * 2^16 / |pivot|, one bit per cycle.
    logic [EW-1:0] acc_mag, piv_mag;
    logic [NW:0]   trial;
    assign acc_mag = acc_reg[EW-1] ? EW'(-acc_reg) : acc_reg;
    assign piv_mag = piv_reg[EW-1] ? EW'(-piv_reg) : piv_reg;
    assign trial   = {rem_reg, dvd_reg[NW-1]} - {{(NW+1-EW){1'b0}}, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.op == OP_DIV_START) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QW);
            rem_reg  <= '0;
            dvd_reg  <= NW'({acc_mag, {FRAC{1'b0}}});
            dvs_reg  <= piv_mag;
            quo_reg  <= '0;
            neg_reg  <= acc_reg[EW-1] ^ piv_reg[EW-1];
        end else if (busy_reg) begin
            if (!trial[NW]) begin
                rem_reg <= trial[NW-1:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[NW-2:0], dvd_reg[NW-1]};
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
            dvd_reg <= {dvd_reg[NW-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign stat.div_busy = busy_reg;
    assign stat.piv_zero = (piv_reg == '0);
    assign stat.rd_zero  = (rdata == '0);
    assign rd_value      = 32'(rdata);
endmodule

FILE: rtl/lud_ctrl.sv
// ----------------------------------------------------------------------------
// lud_ctrl: sequencer for load, factorization and readout
// Walks i, j, k of Doolittle's method and issues datapath commands.
// ----------------------------------------------------------------------------
module lud_ctrl #(
    parameter int MAX_SIZE = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [3:0]           cfg_size,
    input  logic                 cfg_we,
    input  logic                 in_fire,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           out_row,
    output logic [2:0]           out_col,
    output logic                 out_last,
    output logic                 out_sing,
    output lud_pkg::lud_cmd_t    cmd,
    input  lud_pkg::lud_stat_t   stat,
    output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] waddr,
    output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] raddr
);
    import lud_pkg::*;

    localparam int IW = $clog2(MAX_SIZE + 1);
    localparam int XW = $clog2(MAX_SIZE);
    localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);

    lud_state_t state_reg, state_next;
    logic [3:0]    size_reg;
    logic [IW-1:0] n;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IW-1:0] r_reg, r_next, c_reg, c_next;
    logic          sing_reg, sing_next;
    logic          lmode_reg, lmode_next;   // computing L column
    logic          obuf_reg, obuf_next;     // readout word buffered

    // Effective size.
    always_comb begin
        if (size_reg == 4'd0) begin
            n = IW'(1);
        end else if ({1'b0, size_reg} > 5'(MAX_SIZE)) begin
            n = IW'(MAX_SIZE);
        end else begin
            n = IW'(size_reg);
        end
    end

    function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        addr = AW'(r[XW-1:0] * MAX_SIZE) + AW'(c[XW-1:0]);
    endfunction

    // State and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            size_reg  <= 4'd8;
            r_reg     <= '0;
            c_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            sing_reg  <= 1'b0;
            lmode_reg <= 1'b0;
            obuf_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            sing_reg  <= sing_next;
            lmode_reg <= lmode_next;
            obuf_reg  <= obuf_next;
            if (cfg_we) begin
                size_reg <= cfg_size;
                r_reg    <= '0;
                c_reg    <= '0;
            end
        end
    end

    // Next state and commands.
    always_comb begin
        logic [IW-1:0] rr, cc;
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        sing_next  = sing_reg;
        lmode_next = lmode_reg;
        obuf_next  = obuf_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        rr         = lmode_reg ? j_reg : i_reg;
        cc         = lmode_reg ? i_reg : j_reg;
        waddr      = addr(rr, cc);
        raddr      = addr(rr, cc);

        unique case (state_reg)
            ST_LOAD: begin
                in_ready = 1'b1;
                waddr    = addr(r_reg, c_reg);
                if (in_fire) begin
                    cmd.wr_in = 1'b1;
                    if (c_reg == n - 1'b1) begin
                        c_next = '0;
                        if (r_reg == n - 1'b1) begin
                            r_next     = '0;
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            lmode_next = 1'b0;
                            sing_next  = 1'b0;
                            state_next = ST_ACC_RD;
                        end else begin
                            r_next = r_reg + 1'b1;
                        end
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            ST_ACC_RD: begin
                // In L mode the pivot is already loaded; read the element.
                raddr      = addr(rr, cc);
                k_next     = '0;
                state_next = ST_ACC_WAIT;
            end
            ST_ACC_WAIT: begin
                cmd.op = OP_LOAD_ACC;
                state_next = (k_reg == i_reg) ? ST_DIV : ST_MUL_RD;
                raddr = addr(rr, k_reg);
            end
            ST_MUL_RD: begin
                // Address for L[rr][k] already issued; load A and read U[k][cc].
                cmd.op     = OP_LOAD_A;
                raddr      = addr(k_reg, cc);
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                cmd.op     = OP_LOAD_B;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.op     = OP_MUL;
                state_next = ST_SUB;
            end
            ST_SUB: begin
                cmd.op     = OP_SUB;
                k_next     = k_reg + 1'b1;
                raddr      = addr(rr, k_reg + 1'b1);
                state_next = (k_reg + 1'b1 == i_reg) ? ST_DIV : ST_MUL_RD;
            end
            ST_DIV: begin
                // U entries write directly; L entries divide by the pivot, or write zero if it is zero.
                if (lmode_reg && !stat.piv_zero) begin
                    cmd.op     = OP_DIV_START;
                end
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!stat.div_busy) begin
                    cmd.wr_acc = 1'b1;
                    if (lmode_reg) begin
                        cmd.div_zero = stat.piv_zero;
                        cmd.use_quot = ~stat.piv_zero;
                    end
                    state_next = ST_ACC_RD;
                    if (!lmode_reg) begin
                        if (j_reg == n - 1'b1) begin
                            // Row of U done; load pivot U[i][i].
                            raddr      = addr(i_reg, i_reg);
                            state_next = ST_OUT_HOLD;
                            lmode_next = 1'b1;
                            j_next     = i_reg + 1'b1;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end else if (j_reg == n - 1'b1) begin
                        lmode_next = 1'b0;
                        i_next     = i_reg + 1'b1;
                        j_next     = i_reg + 1'b1;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            ST_OUT_HOLD: begin
                // Read the pivot again now that the last U write has landed.
                raddr      = addr(i_reg, i_reg);
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (!lmode_reg) begin
                    // Readout data arrives: present it.
                    out_valid = 1'b1;
                    raddr     = addr(r_reg, c_reg);
                    if (out_ready) begin
                        if (c_reg == n - 1'b1 && r_reg == n - 1'b1) begin
                            r_next     = '0;
                            c_next     = '0;
                            state_next = ST_LOAD;
                        end else begin
                            if (c_reg == n - 1'b1) begin
                                c_next = '0;
                                r_next = r_reg + 1'b1;
                            end else begin
                                c_next = c_reg + 1'b1;
                            end
                            state_next = ST_OUT_RD;
                        end
                    end
                end else begin
                    cmd.op = OP_LOAD_PIV;
                    if (stat.rd_zero) begin
                        sing_next = 1'b1;
                    end
                    state_next = ST_ACC_RD;
                    if (j_reg == n) begin
                        lmode_next = 1'b0;
                        i_next     = i_reg + 1'b1;
                        j_next     = i_reg + 1'b1;
                        if (i_reg + 1'b1 == n) begin
                            state_next = ST_OUT_RD;
                        end
                    end
                end
            end
            ST_OUT_RD: begin
                raddr      = addr(r_reg, c_reg);
                state_next = ST_OUT_WAIT;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign out_row  = 3'(r_reg);
    assign out_col  = 3'(c_reg);
    assign out_last = (r_reg == n - 1'b1) && (c_reg == n - 1'b1);
    assign out_sing = sing_reg;
endmodule
